// File: hdl/twp_pkg.sv
// types and constants shared by the tile window paging block
// no dependencies

package twp_pkg;

   localparam int POS_W  = 24;
   localparam int FRAC_W = 8;
   localparam int IDX_W  = 16;
   localparam int SIDE_W = 3;
   localparam int THR_W  = 8;
   localparam int CELL_W = IDX_W + 2;

   localparam logic [SIDE_W-1:0] MAX_SIDE  = 3'd4;
   localparam logic [THR_W-1:0]  THR_RESET = 8'd192;

   localparam logic ACT_FREE = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0]  old_row;
      logic [IDX_W-1:0]  old_col;
      logic [SIDE_W-1:0] old_rows;
      logic [SIDE_W-1:0] old_cols;
      logic [IDX_W-1:0]  new_row;
      logic [IDX_W-1:0]  new_col;
      logic [SIDE_W-1:0] new_rows;
      logic [SIDE_W-1:0] new_cols;
   } job_type;

   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] tile_row;
      logic [IDX_W-1:0] tile_col;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_OLD,
      SCAN_NEW,
      SCAN_FLUSH
   } scan_state_type;

endpackage

// File: hdl/twp_front.sv
// front end: snaps the origin with hysteresis, clamps the size, holds the window
// state and queues a job whenever the window changes; depends on twp_pkg

module twp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [twp_pkg::POS_W-1:0]   pos_col,
   input  logic [twp_pkg::POS_W-1:0]   pos_row,
   input  logic [twp_pkg::SIDE_W-1:0]  width_tiles,
   input  logic [twp_pkg::SIDE_W-1:0]  height_tiles,
   input  logic                        csr_write,
   input  logic [twp_pkg::THR_W-1:0]   csr_wdata,
   output logic                        job_push,
   output twp_pkg::job_type            job
);

   logic [twp_pkg::IDX_W-1:0]  origin_row_ff, origin_col_ff;
   logic [twp_pkg::SIDE_W-1:0] rows_held_ff, cols_held_ff;
   logic [twp_pkg::THR_W-1:0]  threshold_ff;

   logic [twp_pkg::IDX_W-1:0]  origin_row_in, origin_col_in;
   logic [twp_pkg::SIDE_W-1:0] rows_held_in, cols_held_in;
   logic                       changed;

   function automatic logic [twp_pkg::IDX_W-1:0] snap_axis(
      input logic [twp_pkg::IDX_W-1:0] old,
      input logic [twp_pkg::POS_W-1:0] pos,
      input logic [twp_pkg::THR_W-1:0] thr
   );
      logic signed [twp_pkg::POS_W:0]  scaled;
      logic signed [twp_pkg::POS_W:0]  p;
      logic signed [twp_pkg::POS_W:0]  thr_s;
      logic signed [twp_pkg::POS_W:0]  down;
      logic signed [twp_pkg::POS_W:0]  up;
      logic [twp_pkg::IDX_W-1:0]       fl;
      logic                            frac_nz;
      scaled  = $signed({old[twp_pkg::IDX_W-1], old, {twp_pkg::FRAC_W{1'b0}}});
      p       = $signed({pos[twp_pkg::POS_W-1], pos});
      thr_s   = $signed({{(twp_pkg::POS_W+1-twp_pkg::THR_W){1'b0}}, thr});
      down    = scaled - p;
      up      = p - scaled;
      fl      = pos[twp_pkg::POS_W-1:twp_pkg::FRAC_W];
      frac_nz = |pos[twp_pkg::FRAC_W-1:0];
      if (down > thr_s) begin
         return fl;
      end else if (up > thr_s) begin
         // ceiling saturates at the top of the index range
         if (fl == {1'b0, {(twp_pkg::IDX_W-1){1'b1}}} && frac_nz) begin
            return fl;
         end
         return fl + {{(twp_pkg::IDX_W-1){1'b0}}, frac_nz};
      end
      return old;
   endfunction

   always_comb begin
      origin_col_in = snap_axis(origin_col_ff, pos_col, threshold_ff);
      origin_row_in = snap_axis(origin_row_ff, pos_row, threshold_ff);
      cols_held_in  = (width_tiles > twp_pkg::MAX_SIDE) ? twp_pkg::MAX_SIDE : width_tiles;
      rows_held_in  = (height_tiles > twp_pkg::MAX_SIDE) ? twp_pkg::MAX_SIDE : height_tiles;
      changed       = (origin_row_in != origin_row_ff) || (origin_col_in != origin_col_ff) ||
                      (rows_held_in != rows_held_ff) || (cols_held_in != cols_held_ff);
   end

   assign job_push     = accept && changed;
   assign job.old_row  = origin_row_ff;
   assign job.old_col  = origin_col_ff;
   assign job.old_rows = rows_held_ff;
   assign job.old_cols = cols_held_ff;
   assign job.new_row  = origin_row_in;
   assign job.new_col  = origin_col_in;
   assign job.new_rows = rows_held_in;
   assign job.new_cols = cols_held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_row_ff <= '0;
         origin_col_ff <= '0;
         rows_held_ff  <= '0;
         cols_held_ff  <= '0;
         threshold_ff  <= twp_pkg::THR_RESET;
      end else begin
         if (csr_write) begin
            threshold_ff <= csr_wdata;
         end
         if (accept) begin
            origin_row_ff <= origin_row_in;
            origin_col_ff <= origin_col_in;
            rows_held_ff  <= rows_held_in;
            cols_held_ff  <= cols_held_in;
         end
      end
   end

endmodule

// File: hdl/twp_job_queue.sv
// short job queue between the front end and the tile scanner
// depends on twp_pkg

module twp_job_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  twp_pkg::job_type data_in,
   input  logic             pop,
   output twp_pkg::job_type data_out,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   twp_pkg::job_type  mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// File: hdl/twp_back.sv
// back end: walks the old rectangle then the new one, one tile a cycle unless
// the output stalls, and emits free and load requests through a hold stage and
// an output register; depends on twp_pkg

module twp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  twp_pkg::job_type q_data,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_valid,
   output twp_pkg::rsp_type rsp
);

   twp_pkg::scan_state_type    state_ff, state_in;
   twp_pkg::job_type           job_ff;
   logic [twp_pkg::SIDE_W-1:0] dr_ff, dc_ff;
   twp_pkg::rsp_type           hold_ff, out_ff;
   logic                       hold_valid_ff, out_valid_ff;

   logic                       phase_old, in_scan, rect_empty, last_cell;
   logic                       emit, out_ready, stall, step;
   logic                       push_hold, push_last, load_hold;
   logic [twp_pkg::IDX_W-1:0]  base_r, base_c, oth_r, oth_c;
   logic [twp_pkg::SIDE_W-1:0] rows, cols, oth_rows, oth_cols;
   logic [twp_pkg::CELL_W-1:0] cell_r, cell_c;

   function automatic logic in_span(
      input logic [twp_pkg::CELL_W-1:0] v,
      input logic [twp_pkg::IDX_W-1:0]  lo,
      input logic [twp_pkg::SIDE_W-1:0] len
   );
      logic [twp_pkg::CELL_W-1:0] d;
      d = v - {{2{lo[twp_pkg::IDX_W-1]}}, lo};
      return !d[twp_pkg::CELL_W-1] &&
             (d < {{(twp_pkg::CELL_W-twp_pkg::SIDE_W){1'b0}}, len});
   endfunction

   always_comb begin
      phase_old = (state_ff == twp_pkg::SCAN_OLD);
      in_scan   = (state_ff == twp_pkg::SCAN_OLD) || (state_ff == twp_pkg::SCAN_NEW);
      base_r    = phase_old ? job_ff.old_row  : job_ff.new_row;
      base_c    = phase_old ? job_ff.old_col  : job_ff.new_col;
      rows      = phase_old ? job_ff.old_rows : job_ff.new_rows;
      cols      = phase_old ? job_ff.old_cols : job_ff.new_cols;
      oth_r     = phase_old ? job_ff.new_row  : job_ff.old_row;
      oth_c     = phase_old ? job_ff.new_col  : job_ff.old_col;
      oth_rows  = phase_old ? job_ff.new_rows : job_ff.old_rows;
      oth_cols  = phase_old ? job_ff.new_cols : job_ff.old_cols;
      cell_r    = {{2{base_r[twp_pkg::IDX_W-1]}}, base_r} +
                  {{(twp_pkg::CELL_W-twp_pkg::SIDE_W){1'b0}}, dr_ff};
      cell_c    = {{2{base_c[twp_pkg::IDX_W-1]}}, base_c} +
                  {{(twp_pkg::CELL_W-twp_pkg::SIDE_W){1'b0}}, dc_ff};
      rect_empty = (rows == '0) || (cols == '0);
      last_cell  = (dr_ff == rows - twp_pkg::SIDE_W'(1)) &&
                   (dc_ff == cols - twp_pkg::SIDE_W'(1));
      emit       = !(in_span(cell_r, oth_r, oth_rows) && in_span(cell_c, oth_c, oth_cols));
      out_ready  = !out_valid_ff || rsp_pop;
      stall      = emit && hold_valid_ff && !out_ready;
      step       = in_scan && !rect_empty && !stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twp_pkg::SCAN_IDLE: begin
            if (!q_empty) state_in = twp_pkg::SCAN_OLD;
         end
         twp_pkg::SCAN_OLD: begin
            if (rect_empty || (step && last_cell)) state_in = twp_pkg::SCAN_NEW;
         end
         twp_pkg::SCAN_NEW: begin
            if (rect_empty || (step && last_cell)) state_in = twp_pkg::SCAN_FLUSH;
         end
         twp_pkg::SCAN_FLUSH: begin
            if (!hold_valid_ff || out_ready) state_in = twp_pkg::SCAN_IDLE;
         end
         default: state_in = twp_pkg::SCAN_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = 1'b0;
      push_hold = 1'b0;
      push_last = 1'b0;
      load_hold = 1'b0;
      case (state_ff)
         twp_pkg::SCAN_IDLE: begin
            q_pop = !q_empty;
         end
         twp_pkg::SCAN_OLD, twp_pkg::SCAN_NEW: begin
            load_hold = step && emit;
            push_hold = step && emit && hold_valid_ff;
         end
         twp_pkg::SCAN_FLUSH: begin
            push_hold = hold_valid_ff && out_ready;
            push_last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_data;
      end
      if (load_hold) begin
         hold_ff <= '{action:   phase_old ? twp_pkg::ACT_FREE : twp_pkg::ACT_LOAD,
                      tile_row: cell_r[twp_pkg::IDX_W-1:0],
                      tile_col: cell_c[twp_pkg::IDX_W-1:0],
                      last:     1'b0};
      end
      if (push_hold) begin
         out_ff <= '{action:   hold_ff.action,
                     tile_row: hold_ff.tile_row,
                     tile_col: hold_ff.tile_col,
                     last:     push_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= twp_pkg::SCAN_IDLE;
         dr_ff         <= '0;
         dc_ff         <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (step) begin
            if (dc_ff == cols - twp_pkg::SIDE_W'(1)) begin
               dc_ff <= '0;
               dr_ff <= last_cell ? '0 : dr_ff + twp_pkg::SIDE_W'(1);
            end else begin
               dc_ff <= dc_ff + twp_pkg::SIDE_W'(1);
            end
         end
         if (load_hold) begin
            hold_valid_ff <= 1'b1;
         end else if (push_hold) begin
            hold_valid_ff <= 1'b0;
         end
         if (push_hold) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

// File: hdl/tile_window_paging.sv
// tile working set pager: top level joining front end, job queue and scanner
// depends on twp_pkg, twp_front, twp_job_queue and twp_back
//
// usage: each transfer on the req_ channel gives a window corner in tile
// units (signed q16.8) and a window size. when the snapped origin or the size
// changes, free requests for dropped tiles and then load requests for new
// tiles come out on the rsp_ channel in row-major order, rsp_last on the final
// one. an item that leaves the window unchanged gives no response.
// the front end classifies an item in its accept cycle and registers the job in
// the job queue; an idle scanner then moves it into its job register and walks
// it. each request waits in a hold stage until the next one is found or the walk
// ends, and then moves to the output register.
// the front end takes one item per cycle while req_full is low; the scanner
// walks one changed window at a time, one tile per cycle while the output
// does not stall, and takes the next job only when the walk is done.
// req_full rises when JOB_DEPTH changed windows are waiting.
// csr_write sets the snap threshold (q0.8 tiles); write only while idle.
// reset: synchronous, clears origin and size to zero, threshold to 0.75,
// empties both queues. when rsp_pop stays low the scanner stops at the next
// request and the job queue then fills and raises req_full.

module tile_window_paging #(
   parameter int JOB_DEPTH = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [twp_pkg::POS_W-1:0]   req_pos_col,
   input  logic signed [twp_pkg::POS_W-1:0]   req_pos_row,
   input  logic [twp_pkg::SIDE_W-1:0]         req_width_tiles,
   input  logic [twp_pkg::SIDE_W-1:0]         req_height_tiles,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_action,
   output logic signed [twp_pkg::IDX_W-1:0]   rsp_tile_row,
   output logic signed [twp_pkg::IDX_W-1:0]   rsp_tile_col,
   output logic                               rsp_last,
   input  logic                               csr_write,
   input  logic [twp_pkg::THR_W-1:0]          csr_wdata
);

   logic             accept, job_push, q_full, q_empty, q_pop, rsp_valid;
   twp_pkg::job_type job_in, job_out;
   twp_pkg::rsp_type rsp;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   twp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pos_col      (req_pos_col),
      .pos_row      (req_pos_row),
      .width_tiles  (req_width_tiles),
      .height_tiles (req_height_tiles),
      .csr_write    (csr_write),
      .csr_wdata    (csr_wdata),
      .job_push     (job_push),
      .job          (job_in)
   );

   twp_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .data_in  (job_in),
      .pop      (q_pop),
      .data_out (job_out),
      .full     (q_full),
      .empty    (q_empty)
   );

   twp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (job_out),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_empty    = !rsp_valid;
   assign rsp_action   = rsp.action;
   assign rsp_tile_row = rsp.tile_row;
   assign rsp_tile_col = rsp.tile_col;
   assign rsp_last     = rsp.last;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full)
      else $error("job pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("scanner took a job from an empty queue");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response present straight after reset");

endmodule
